[rtl/core/nch_pkg.sv]
// shared types and constants for the nearest center histogram
package nch_pkg;

  // default sizes
  localparam int MAX_CENTERS_DEF = 64;
  localparam int COORD_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF  = 32;

  // fixed field widths
  localparam int MODE_BITS      = 2;
  localparam int SLOT_BITS      = 6;
  localparam int BIN_BITS       = 6;
  localparam int OUT_COUNT_BITS = 32;
  localparam int CFG_BITS       = 7;
  localparam int OUT_TDATA_BITS = ((BIN_BITS + OUT_COUNT_BITS + 7) / 8) * 8;

  localparam logic [CFG_BITS-1:0] CENTERS_RESET = 7'd64;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD,
    MODE_CLASSIFY,
    MODE_READ
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_CNT,
    ST_OUT
  } state_t;

  // control that rides along with one center through the distance pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } dist_ctl_t;

endpackage

[rtl/core/nch_dist.sv]
// squared distance pipeline with running minimum over the centers of one point
module nch_dist #(
  parameter int IW         = 6,
  parameter int COORD_BITS = nch_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  nch_pkg::dist_ctl_t    ctl,
  input  logic [IW-1:0]         idx,
  input  logic [COORD_BITS-1:0] ctr_x,
  input  logic [COORD_BITS-1:0] ctr_y,
  input  logic [COORD_BITS-1:0] ctr_z,
  input  logic [COORD_BITS-1:0] pt_x,
  input  logic [COORD_BITS-1:0] pt_y,
  input  logic [COORD_BITS-1:0] pt_z,
  output logic                  done,
  output logic [IW-1:0]         best_idx
);

  localparam int SQ_BITS = 2 * COORD_BITS;
  localparam int DW      = SQ_BITS + 2;

  localparam logic [COORD_BITS-1:0] SIGN = {1'b1, {(COORD_BITS-1){1'b0}}};

  nch_pkg::dist_ctl_t ctl1, ctl2, ctl3;
  logic [IW-1:0]         idx1, idx2, idx3;
  logic [COORD_BITS-1:0] dx, dy, dz;
  logic [SQ_BITS-1:0]    sqx, sqy, sqz;
  logic [DW-1:0]         dsum, best_d;

  logic [COORD_BITS-1:0] px_b, py_b, pz_b, cx_b, cy_b, cz_b;

  // offset binary keeps signed order under unsigned compare
  assign px_b = pt_x ^ SIGN;
  assign py_b = pt_y ^ SIGN;
  assign pz_b = pt_z ^ SIGN;
  assign cx_b = ctr_x ^ SIGN;
  assign cy_b = ctr_y ^ SIGN;
  assign cz_b = ctr_z ^ SIGN;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      done <= 1'b0;
    end else begin
      ctl1 <= ctl;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      done <= ctl3.valid && ctl3.last;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: absolute differences
    idx1 <= idx;
    dx   <= (px_b >= cx_b) ? px_b - cx_b : cx_b - px_b;
    dy   <= (py_b >= cy_b) ? py_b - cy_b : cy_b - py_b;
    dz   <= (pz_b >= cz_b) ? pz_b - cz_b : cz_b - pz_b;
    // stage 2: squares
    idx2 <= idx1;
    sqx  <= SQ_BITS'(dx) * SQ_BITS'(dx);
    sqy  <= SQ_BITS'(dy) * SQ_BITS'(dy);
    sqz  <= SQ_BITS'(dz) * SQ_BITS'(dz);
    // stage 3: sum
    idx3 <= idx2;
    dsum <= DW'(sqx) + DW'(sqy) + DW'(sqz);
    // stage 4: strict less keeps the lowest index on a tie
    if (ctl3.valid && (ctl3.first || dsum < best_d)) begin
      best_d   <= dsum;
      best_idx <= idx3;
    end
  end

endmodule

[rtl/core/nearest_center_histogram.sv]
// nearest center histogram top level: center table, bin counters and sequencer
//
//  channel  | signals                         | contents
//  ---------+---------------------------------+---------------------------------
//  s_axis   | tvalid tready tdata tuser       | tuser: mode; tdata: slot, x, y, z
//  m_axis   | tvalid tready tdata             | tdata: bin, bin_count
//  cfg      | valid ready data                | centers_in_use, always ready
//
//  load: the center is written at the transfer
//  read: the counter is read at the transfer, then the result register is
//    loaded from it; the next item is taken once the result is on m_axis
//  classify: the center table gives one center per cycle into a four stage
//    distance pipeline, over the centers searched
//  after reset the counters are cleared, one per cycle, with s_axis_tready low
//  a result waiting on m_axis does not block the next transfer on s_axis
module nearest_center_histogram #(
  parameter int MAX_CENTERS = nch_pkg::MAX_CENTERS_DEF,
  parameter int COORD_BITS  = nch_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS  = nch_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // slot, coord_x, coord_y, coord_z from bit 0 up, zero fill to bytes
  input  logic [((nch_pkg::SLOT_BITS + 3*COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // mode
  input  logic [nch_pkg::MODE_BITS-1:0]          s_axis_tuser,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // bin, bin_count from bit 0 up, zero fill to bytes
  output logic [nch_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic [nch_pkg::CFG_BITS-1:0]           cfg_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready
);

  localparam int IW  = $clog2(MAX_CENTERS);
  // wide enough for a slot, an index and MAX_CENTERS itself
  localparam int WW  = (IW + 1 > nch_pkg::SLOT_BITS) ? IW + 1 : nch_pkg::SLOT_BITS;
  localparam int CMW = (IW + 1 > nch_pkg::CFG_BITS) ? IW + 1 : nch_pkg::CFG_BITS;
  localparam int OW  = (COUNT_BITS > nch_pkg::OUT_COUNT_BITS) ? COUNT_BITS
                                                              : nch_pkg::OUT_COUNT_BITS;
  localparam int CTR_BITS = 3 * COORD_BITS;

  nch_pkg::state_t state, state_next;

  // config register
  logic [nch_pkg::CFG_BITS-1:0] centers_in_use;

  // input unpack
  nch_pkg::mode_t                in_mode;
  logic [nch_pkg::SLOT_BITS-1:0] in_slot;
  logic [CTR_BITS-1:0]           in_coords;
  logic [WW-1:0]                 in_slot_w;
  logic                          in_range;
  logic [IW-1:0]                 in_idx;
  logic                          in_xfer;

  // effective search count
  logic [CMW-1:0] cfg_w, n_eff, n_last;

  // memories
  logic [CTR_BITS-1:0]   ctr_mem [MAX_CENTERS];
  logic [COUNT_BITS-1:0] cnt_mem [MAX_CENTERS];
  logic [CTR_BITS-1:0]   ctr_rdata;
  logic [COUNT_BITS-1:0] cnt_rdata;

  // sequencer
  logic [IW-1:0]           clr_idx, scan_idx, scan_last, cnt_addr;
  logic [CTR_BITS-1:0]     point;
  logic                    item_cls, item_range;
  logic [nch_pkg::SLOT_BITS-1:0] item_slot;
  logic [nch_pkg::BIN_BITS-1:0]  res_bin;
  logic [nch_pkg::OUT_COUNT_BITS-1:0] res_count;

  // control from the state decode
  logic          ctr_we, cnt_re, cnt_we, out_load;
  logic [IW-1:0] cnt_raddr, cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_inc;
  logic [OW-1:0] cnt_inc_w, cnt_rd_w;
  logic [WW-1:0] best_w;

  // distance pipeline link
  nch_pkg::dist_ctl_t dist_ctl;
  logic [IW-1:0]      dist_idx, dist_best;
  logic               dist_done;

  assign in_mode   = nch_pkg::mode_t'(s_axis_tuser);
  assign in_slot   = s_axis_tdata[nch_pkg::SLOT_BITS-1:0];
  assign in_coords = s_axis_tdata[nch_pkg::SLOT_BITS +: CTR_BITS];
  assign in_slot_w = WW'(in_slot);
  assign in_range  = in_slot_w < WW'(MAX_CENTERS);
  assign in_idx    = in_slot_w[IW-1:0];
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  assign cfg_ready = 1'b1;

  // zero counts as one, large values stop at the table size
  assign cfg_w  = CMW'(centers_in_use);
  assign n_eff  = (cfg_w == '0) ? CMW'(1)
                : (cfg_w > CMW'(MAX_CENTERS)) ? CMW'(MAX_CENTERS) : cfg_w;
  assign n_last = n_eff - CMW'(1);

  // saturating increment of the counter that was read
  assign cnt_inc   = (cnt_rdata == {COUNT_BITS{1'b1}}) ? cnt_rdata
                                                       : cnt_rdata + COUNT_BITS'(1);
  assign cnt_inc_w = OW'(cnt_inc);
  assign cnt_rd_w  = OW'(cnt_rdata);
  assign best_w    = WW'(cnt_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nch_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    ctr_we        = 1'b0;
    cnt_re        = 1'b0;
    cnt_raddr     = in_idx;
    cnt_we        = 1'b0;
    cnt_waddr     = clr_idx;
    cnt_wdata     = '0;
    out_load      = 1'b0;
    unique case (state)
      nch_pkg::ST_CLEAR: begin
        cnt_we = 1'b1;
        if (clr_idx == IW'(MAX_CENTERS - 1)) begin
          state_next = nch_pkg::ST_IDLE;
        end
      end
      nch_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          unique case (in_mode)
            nch_pkg::MODE_LOAD: begin
              ctr_we = in_range;
            end
            nch_pkg::MODE_CLASSIFY: begin
              state_next = nch_pkg::ST_SCAN;
            end
            nch_pkg::MODE_READ: begin
              cnt_re     = in_range;
              state_next = nch_pkg::ST_CNT;
            end
            default: ;
          endcase
        end
      end
      nch_pkg::ST_SCAN: begin
        if (scan_idx == scan_last) begin
          state_next = nch_pkg::ST_WAIT;
        end
      end
      nch_pkg::ST_WAIT: begin
        cnt_raddr = dist_best;
        if (dist_done) begin
          cnt_re     = 1'b1;
          state_next = nch_pkg::ST_CNT;
        end
      end
      nch_pkg::ST_CNT: begin
        // on classify, write back the incremented count of the winning bin
        cnt_we     = item_cls;
        cnt_waddr  = cnt_addr;
        cnt_wdata  = cnt_inc;
        state_next = nch_pkg::ST_OUT;
      end
      nch_pkg::ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = nch_pkg::ST_IDLE;
        end
      end
      default: state_next = nch_pkg::ST_IDLE;
    endcase
  end

  // config write
  always_ff @(posedge clk) begin
    if (rst) begin
      centers_in_use <= nch_pkg::CENTERS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      centers_in_use <= cfg_data;
    end
  end

  // center table: written by load transfers, read once per scan cycle
  always_ff @(posedge clk) begin
    if (ctr_we) begin
      ctr_mem[in_idx] <= in_coords;
    end
    if (state == nch_pkg::ST_SCAN) begin
      ctr_rdata <= ctr_mem[scan_idx];
    end
  end

  // bin counters: cleared after reset, then read, and on classify bumped and written back
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata <= cnt_mem[cnt_raddr];
    end
  end

  // sequencer registers with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx       <= '0;
      dist_ctl      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == nch_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + IW'(1);
      end
      dist_ctl.valid <= (state == nch_pkg::ST_SCAN);
      dist_ctl.first <= (scan_idx == '0);
      dist_ctl.last  <= (scan_idx == scan_last);
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dist_idx <= scan_idx;
    if (in_xfer) begin
      point      <= in_coords;
      item_cls   <= (in_mode == nch_pkg::MODE_CLASSIFY);
      item_slot  <= in_slot;
      item_range <= in_range;
      cnt_addr   <= in_idx;
      scan_idx   <= '0;
      scan_last  <= n_last[IW-1:0];
    end else if (state == nch_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + IW'(1);
    end
    if (state == nch_pkg::ST_WAIT) begin
      cnt_addr <= dist_best;
    end
    if (state == nch_pkg::ST_CNT) begin
      if (item_cls) begin
        res_bin   <= best_w[nch_pkg::BIN_BITS-1:0];
        res_count <= cnt_inc_w[nch_pkg::OUT_COUNT_BITS-1:0];
      end else begin
        // read transfer: echo the slot, out of range reads give zero
        res_bin   <= item_slot;
        res_count <= item_range ? cnt_rd_w[nch_pkg::OUT_COUNT_BITS-1:0] : '0;
      end
    end
    if (out_load) begin
      m_axis_tdata <= nch_pkg::OUT_TDATA_BITS'({res_count, res_bin});
    end
  end

  nch_dist #(
    .IW         (IW),
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dist_ctl),
    .idx      (dist_idx),
    .ctr_x    (ctr_rdata[0 +: COORD_BITS]),
    .ctr_y    (ctr_rdata[COORD_BITS +: COORD_BITS]),
    .ctr_z    (ctr_rdata[2*COORD_BITS +: COORD_BITS]),
    .pt_x     (point[0 +: COORD_BITS]),
    .pt_y     (point[COORD_BITS +: COORD_BITS]),
    .pt_z     (point[2*COORD_BITS +: COORD_BITS]),
    .done     (dist_done),
    .best_idx (dist_best)
  );

  // the pipeline reports only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    dist_done |-> state == nch_pkg::ST_WAIT)
    else $error("distance result outside wait state");

  // scan never runs past the last searched center
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == nch_pkg::ST_SCAN |-> scan_idx <= scan_last)
    else $error("scan index beyond last center");

  // the winner is one of the searched centers
  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    dist_done |-> dist_best <= scan_last)
    else $error("nearest center outside searched range");

  // no counter is bumped before the clearing pass is over
  a_no_early_bump: assert property (@(posedge clk) disable iff (rst)
    state == nch_pkg::ST_CNT |-> $past(state) != nch_pkg::ST_CLEAR)
    else $error("counter update straight after clear");

endmodule
